// ===== rtl/core/alusf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package alusf_pkg;

  localparam int unsigned WORD_W = 16;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned OP_W   = 4;
  localparam int unsigned COND_W = 4;
  localparam int unsigned FLAG_W = 4;

  // flag bit positions in the packed status nibble
  localparam int unsigned FLAG_N_BIT = 3;
  localparam int unsigned FLAG_Z_BIT = 2;
  localparam int unsigned FLAG_V_BIT = 1;
  localparam int unsigned FLAG_C_BIT = 0;

  localparam logic [WORD_W-1:0] WORD_MIN_NEG = 16'h8000;

  typedef enum logic [OP_W-1:0] {
    OP_NEG    = 4'd0,
    OP_ASL    = 4'd1,
    OP_ASR    = 4'd2,
    OP_NOT    = 4'd3,
    OP_ROL    = 4'd4,
    OP_ROR    = 4'd5,
    OP_ADD    = 4'd6,
    OP_SUB    = 4'd7,
    OP_AND    = 4'd8,
    OP_OR     = 4'd9,
    OP_XOR    = 4'd10,
    OP_CPW    = 4'd11,
    OP_CPB    = 4'd12,
    OP_LDW    = 4'd13,
    OP_LDB    = 4'd14,
    OP_BRANCH = 4'd15
  } op_t;

  typedef enum logic [COND_W-1:0] {
    COND_ALWAYS = 4'd0,
    COND_LE     = 4'd1,
    COND_LT     = 4'd2,
    COND_EQ     = 4'd3,
    COND_NE     = 4'd4,
    COND_GE     = 4'd5,
    COND_GT     = 4'd6,
    COND_V      = 4'd7,
    COND_C      = 4'd8
  } cond_t;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic              reg_select;
    logic [WORD_W-1:0] operand;
    logic [COND_W-1:0] branch_condition;
  } item_t;

  typedef struct packed {
    logic [WORD_W-1:0] result;
    logic [FLAG_W-1:0] flags;
    logic              branch_taken;
    logic              register_written;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/core/alusf_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface alusf_in_if;
  import alusf_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic              reg_select;
  logic [WORD_W-1:0] operand;
  logic [COND_W-1:0] branch_condition;

  modport source (output valid, operation, reg_select, operand, branch_condition,
                  input ready);
  modport sink   (input valid, operation, reg_select, operand, branch_condition,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/core/alusf_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface alusf_out_if;
  import alusf_pkg::*;

  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] result;
  logic [FLAG_W-1:0] flags;
  logic              branch_taken;
  logic              register_written;

  modport source (output valid, result, flags, branch_taken, register_written,
                  input ready);
  modport sink   (input valid, result, flags, branch_taken, register_written,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/core/alusf_in_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none

module alusf_in_stage (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire alusf_pkg::item_t in_item,
  input  wire logic           advance,
  output logic                stage_valid,
  output alusf_pkg::item_t    stage_item
);
  import alusf_pkg::*;

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;

  // accept when empty or when the held item moves on this cycle
  assign in_ready    = !valid_r || advance;
  assign stage_valid = valid_r;
  assign stage_item  = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload register
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/alusf_exec.sv =====
`timescale 1ns / 1ps
`default_nettype none

module alusf_exec (
  input  wire alusf_pkg::item_t               item,
  input  wire logic [alusf_pkg::WORD_W-1:0]   acc,
  input  wire logic [alusf_pkg::WORD_W-1:0]   xr,
  input  wire logic [alusf_pkg::FLAG_W-1:0]   status,
  output alusf_pkg::res_t                     res_o
);
  import alusf_pkg::*;

  logic [WORD_W-1:0] src;
  logic [WORD_W-1:0] addend;
  logic [WORD_W:0]   sum;
  logic [BYTE_W-1:0] byte_diff;
  logic [WORD_W-1:0] res;
  logic              n;
  logic              z;
  logic              v;
  logic              c;
  logic              set_nz;
  logic              written;
  logic              taken;

  always_comb begin
    src       = item.reg_select ? xr : acc;
    // one adder serves add, sub and word compare
    addend    = (item.operation == OP_ADD) ? item.operand : (WORD_W'(0) - item.operand);
    sum       = {1'b0, src} + {1'b0, addend};
    byte_diff = src[BYTE_W-1:0] - item.operand[BYTE_W-1:0];

    n       = status[FLAG_N_BIT];
    z       = status[FLAG_Z_BIT];
    v       = status[FLAG_V_BIT];
    c       = status[FLAG_C_BIT];
    res     = src;
    set_nz  = 1'b1;
    written = 1'b1;
    taken   = 1'b0;

    case (item.operation)
      OP_NEG: begin
        res = WORD_W'(0) - src;
        v   = (res == WORD_MIN_NEG);
        c   = (src == '0);
      end
      OP_ASL: begin
        res = {src[WORD_W-2:0], 1'b0};
        v   = src[WORD_W-1] ^ src[WORD_W-2];
        c   = src[WORD_W-1];
      end
      OP_ASR: begin
        res = {src[WORD_W-1], src[WORD_W-1:1]};
        v   = 1'b0;
        c   = src[0];
      end
      OP_NOT: begin
        res = ~src;
      end
      OP_ROL: begin
        res = {src[WORD_W-2:0], c};
        c   = src[WORD_W-1];
      end
      OP_ROR: begin
        res = {c, src[WORD_W-1:1]};
        c   = src[0];
      end
      OP_ADD, OP_SUB: begin
        res = sum[WORD_W-1:0];
        v   = ~(src[WORD_W-1] ^ addend[WORD_W-1]) & (src[WORD_W-1] ^ res[WORD_W-1]);
        c   = sum[WORD_W];
      end
      OP_CPW: begin
        res     = sum[WORD_W-1:0];
        v       = ~(src[WORD_W-1] ^ addend[WORD_W-1]) & (src[WORD_W-1] ^ res[WORD_W-1]);
        c       = sum[WORD_W];
        set_nz  = 1'b0;
        n       = res[WORD_W-1] ^ v;
        z       = (res == '0);
        written = 1'b0;
      end
      OP_AND: begin
        res = src & item.operand;
      end
      OP_OR: begin
        res = src | item.operand;
      end
      OP_XOR: begin
        res = src ^ item.operand;
      end
      OP_CPB: begin
        res     = {{(WORD_W-BYTE_W){1'b0}}, byte_diff};
        set_nz  = 1'b0;
        n       = byte_diff[BYTE_W-1];
        z       = (byte_diff == '0);
        v       = 1'b0;
        c       = 1'b0;
        written = 1'b0;
      end
      OP_LDW: begin
        res = item.operand;
      end
      OP_LDB: begin
        res    = {{(WORD_W-BYTE_W){1'b0}}, item.operand[BYTE_W-1:0]};
        set_nz = 1'b0;
        n      = 1'b0;
        z      = (res == '0);
      end
      OP_BRANCH: begin
        set_nz  = 1'b0;
        written = 1'b0;
        // condition is checked on the flags held before this item
        case (item.branch_condition)
          COND_ALWAYS: taken = 1'b1;
          COND_LE:     taken = n || z;
          COND_LT:     taken = n;
          COND_EQ:     taken = z;
          COND_NE:     taken = !z;
          COND_GE:     taken = !n;
          COND_GT:     taken = !n && !z;
          COND_V:      taken = v;
          COND_C:      taken = c;
          default:     taken = 1'b0;
        endcase
      end
      default: begin
        written = 1'b0;
      end
    endcase

    if (set_nz) begin
      n = res[WORD_W-1];
      z = (res == '0);
    end

    res_o.result           = res;
    res_o.flags            = {n, z, v, c};
    res_o.branch_taken     = taken;
    res_o.register_written = written;
  end

endmodule

`default_nettype wire

// ===== rtl/core/alu_with_status_flags.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel  dir  handshake          payload
// in_ch    in   valid/ready        operation, reg_select, operand, branch_condition
// out_ch   out  valid/ready        result, flags, branch_taken, register_written
//
// one item per cycle sustained while out_ch does not stall; an accepted item passes
// through the input register, then the alu logic into the result register
// A, X and flags are written when an item moves into the result register,
// so the next item in the input register always sees them up to date
// reset clears A, X, flags and both valid bits
// a stall on out_ch holds both stages; in_ch stays ready while a slot is free

module alu_with_status_flags (
  input  wire logic clk,
  input  wire logic rst_n,
  alusf_in_if.sink    in_ch,
  alusf_out_if.source out_ch
);
  import alusf_pkg::*;

  item_t             in_item;
  item_t             stage_item;
  logic              stage_valid;
  logic              advance;
  res_t              exec_res;

  logic              out_valid_r;
  logic              out_valid_nxt;
  res_t              out_data_r;
  logic [WORD_W-1:0] acc_r;
  logic [WORD_W-1:0] xr_r;
  logic [FLAG_W-1:0] status_r;

  assign in_item.operation        = in_ch.operation;
  assign in_item.reg_select       = in_ch.reg_select;
  assign in_item.operand          = in_ch.operand;
  assign in_item.branch_condition = in_ch.branch_condition;

  // input register
  alusf_in_stage u_in_stage (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_item     (in_item),
    .advance     (advance),
    .stage_valid (stage_valid),
    .stage_item  (stage_item)
  );

  // alu and flag logic
  alusf_exec u_exec (
    .item   (stage_item),
    .acc    (acc_r),
    .xr     (xr_r),
    .status (status_r),
    .res_o  (exec_res)
  );

  // item moves on when the result register is free or being drained
  assign advance = stage_valid && (!out_valid_r || out_ch.ready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (!out_valid_r || out_ch.ready) begin
      out_valid_nxt = stage_valid;
    end
  end

  // control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      acc_r       <= '0;
      xr_r        <= '0;
      status_r    <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        status_r <= exec_res.flags;
        if (exec_res.register_written) begin
          if (stage_item.reg_select) begin
            xr_r <= exec_res.result;
          end else begin
            acc_r <= exec_res.result;
          end
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= exec_res;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.result           = out_data_r.result;
  assign out_ch.flags            = out_data_r.flags;
  assign out_ch.branch_taken     = out_data_r.branch_taken;
  assign out_ch.register_written = out_data_r.register_written;

  // held result always carries the live flags
  a_flags_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (status_r == out_data_r.flags))
    else $error("status register differs from flags of held result");

  // accumulator write lands with the result
  a_acc_write: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && exec_res.register_written && !stage_item.reg_select)
      |=> (acc_r == out_data_r.result))
    else $error("accumulator not updated with written result");

  // branch leaves registers and flags alone
  a_branch_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && (stage_item.operation == OP_BRANCH))
      |=> ($stable(acc_r) && $stable(xr_r) && $stable(status_r)))
    else $error("branch item changed architectural state");

  // a taken branch never reports a register write
  a_taken_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.branch_taken) |-> !out_data_r.register_written)
    else $error("taken branch flagged as register write");

endmodule

`default_nettype wire

// ===== tb/sv/tb_alu_with_status_flags.sv =====
`timescale 1ns / 1ps

module tb_alu_with_status_flags;
  import alusf_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1000;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned HOLD_START   = 300;
  localparam int unsigned HOLD_CYCLES  = 80;
  localparam int unsigned DRAIN_CYCLES = 6;

  localparam logic              SEL_A        = 1'b0;
  localparam logic              SEL_X        = 1'b1;
  localparam logic [COND_W-1:0] COND_UNKNOWN = 4'd15;

  // shadow copy of A, X and NZVC; predicts one result per accepted instruction
  class nzvc_shadow;
    logic [WORD_W-1:0] acc_q;
    logic [WORD_W-1:0] idx_q;
    logic [FLAG_W-1:0] flags_q;
    res_t              expected_results[$];
    int unsigned       mismatches;
    int unsigned       results_seen;
    int unsigned       taken_count;
    bit                op_seen[16];

    function new();
      acc_q        = '0;
      idx_q        = '0;
      flags_q      = '0;
      mismatches   = 0;
      results_seen = 0;
      taken_count  = 0;
    endfunction

    function bit cond_holds(logic [COND_W-1:0] cond);
      logic n, z, v, c;
      n = flags_q[FLAG_N_BIT];
      z = flags_q[FLAG_Z_BIT];
      v = flags_q[FLAG_V_BIT];
      c = flags_q[FLAG_C_BIT];
      case (cond)
        COND_ALWAYS: return 1'b1;
        COND_LE:     return n | z;
        COND_LT:     return n;
        COND_EQ:     return z;
        COND_NE:     return ~z;
        COND_GE:     return ~n;
        COND_GT:     return ~n & ~z;
        COND_V:      return v;
        COND_C:      return c;
        default:     return 1'b0;
      endcase
    endfunction

    function res_t execute(item_t it);
      op_t               op;
      logic [WORD_W-1:0] src, res, neg;
      logic [BYTE_W-1:0] byte_diff;
      logic [FLAG_W-1:0] f;
      logic              n, z, v, c, wr, tk;
      res_t              r;
      op  = op_t'(it.operation);
      src = it.reg_select ? idx_q : acc_q;
      v   = flags_q[FLAG_V_BIT];
      c   = flags_q[FLAG_C_BIT];
      res = src;
      wr  = 1'b1;
      tk  = 1'b0;
      // datapath and the v/c rules
      case (op)
        OP_NEG: begin
          res = 16'd0 - src;
          v   = (res == WORD_MIN_NEG);
          c   = (src == '0);
        end
        OP_ASL: begin
          res = {src[WORD_W-2:0], 1'b0};
          v   = src[WORD_W-1] ^ res[WORD_W-1];
          c   = src[WORD_W-1];
        end
        OP_ASR: begin
          res = {src[WORD_W-1], src[WORD_W-1:1]};
          v   = 1'b0;
          c   = src[0];
        end
        OP_NOT: res = ~src;
        OP_ROL: begin
          res = {src[WORD_W-2:0], c};
          c   = src[WORD_W-1];
        end
        OP_ROR: begin
          res = {c, src[WORD_W-1:1]};
          c   = src[0];
        end
        OP_ADD: begin
          res = src + it.operand;
          v   = ~(src[WORD_W-1] ^ it.operand[WORD_W-1]) & (src[WORD_W-1] ^ res[WORD_W-1]);
          c   = (res < src) || (res < it.operand);
        end
        OP_SUB, OP_CPW: begin
          neg = 16'd0 - it.operand;
          res = src + neg;
          v   = ~(src[WORD_W-1] ^ neg[WORD_W-1]) & (src[WORD_W-1] ^ res[WORD_W-1]);
          c   = (res < src) || (res < neg);
        end
        OP_AND: res = src & it.operand;
        OP_OR:  res = src | it.operand;
        OP_XOR: res = src ^ it.operand;
        OP_CPB: begin
          byte_diff = src[BYTE_W-1:0] - it.operand[BYTE_W-1:0];
          res       = {8'h00, byte_diff};
        end
        OP_LDW: res = it.operand;
        OP_LDB: res = {8'h00, it.operand[BYTE_W-1:0]};
        default: ;
      endcase
      // n/z and the per-operation exceptions
      n = res[WORD_W-1];
      z = (res == '0);
      case (op)
        OP_CPW: begin
          n  = res[WORD_W-1] ^ v;
          wr = 1'b0;
        end
        OP_CPB: begin
          n  = res[BYTE_W-1];
          v  = 1'b0;
          c  = 1'b0;
          wr = 1'b0;
        end
        OP_LDB: n = 1'b0;
        OP_BRANCH: begin
          n  = flags_q[FLAG_N_BIT];
          z  = flags_q[FLAG_Z_BIT];
          wr = 1'b0;
          tk = cond_holds(it.branch_condition);
        end
        default: ;
      endcase
      f             = '0;
      f[FLAG_N_BIT] = n;
      f[FLAG_Z_BIT] = z;
      f[FLAG_V_BIT] = v;
      f[FLAG_C_BIT] = c;
      flags_q       = f;
      if (wr) begin
        if (it.reg_select) begin
          idx_q = res;
        end else begin
          acc_q = res;
        end
      end
      r.result           = res;
      r.flags            = f;
      r.branch_taken     = tk;
      r.register_written = wr;
      return r;
    endfunction

    function void note_instruction(item_t it);
      res_t r;
      r = execute(it);
      if (r.branch_taken) taken_count++;
      op_seen[it.operation] = 1'b1;
      expected_results.push_back(r);
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (expected_results.size() == 0) begin
        $error("unexpected result item: result %h flags %b", got.result, got.flags);
        mismatches++;
        return;
      end
      want = expected_results.pop_front();
      results_seen++;
      if (got.result !== want.result) begin
        $error("result mismatch: expected %h, got %h", want.result, got.result);
        mismatches++;
      end
      if (got.flags !== want.flags) begin
        $error("flags mismatch: expected %b, got %b", want.flags, got.flags);
        mismatches++;
      end
      if (got.branch_taken !== want.branch_taken) begin
        $error("branch_taken mismatch: expected %b, got %b",
               want.branch_taken, got.branch_taken);
        mismatches++;
      end
      if (got.register_written !== want.register_written) begin
        $error("register_written mismatch: expected %b, got %b",
               want.register_written, got.register_written);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  int unsigned items_sent;
  int unsigned input_stalls;
  int unsigned cycle_count;
  nzvc_shadow  shadow = new();

  alusf_in_if  in_ch();
  alusf_out_if out_ch();

  alu_with_status_flags i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // watch both channels at each edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        shadow.note_instruction(item_t'({in_ch.operation, in_ch.reg_select,
                                         in_ch.operand, in_ch.branch_condition}));
      end
      if (in_ch.valid && !in_ch.ready) input_stalls++;
      if (out_ch.valid && out_ch.ready) begin
        shadow.check_result(res_t'({out_ch.result, out_ch.flags,
                                    out_ch.branch_taken, out_ch.register_written}));
      end
    end
  end

  // run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_alu_with_status_flags: FAIL");
    $finish;
  end

  // result side: ready pattern in random modes, one long hold-off
  initial begin
    int unsigned rcv_cycle;
    int unsigned mode;
    int unsigned mode_left;
    out_ch.ready <= 1'b0;
    rcv_cycle = 0;
    mode_left = 0;
    mode      = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (rcv_cycle == HOLD_START) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        rcv_cycle += HOLD_CYCLES;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 2);
          mode_left = $urandom_range(8, 64);
        end
        mode_left--;
        case (mode)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= ($urandom_range(0, 3) != 0);
          default: out_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
        @(posedge clk);
        rcv_cycle++;
      end
    end
  end

  function automatic item_t mk(op_t op, logic sel, logic [WORD_W-1:0] opnd,
                               logic [COND_W-1:0] cond);
    item_t it;
    it.operation        = op;
    it.reg_select       = sel;
    it.operand          = opnd;
    it.branch_condition = cond;
    return it;
  endfunction

  function automatic item_t random_item();
    item_t it;
    it.operation        = OP_W'($urandom_range(0, 15));
    it.reg_select       = 1'($urandom_range(0, 1));
    it.branch_condition = COND_W'($urandom_range(0, 15));
    // bias toward the corner words so flag edges come up often
    case ($urandom_range(0, 9))
      0:       it.operand = 16'h0000;
      1:       it.operand = 16'hFFFF;
      2:       it.operand = 16'h8000;
      3:       it.operand = 16'h7FFF;
      4:       it.operand = 16'h0001;
      5:       it.operand = {8'h00, 8'($urandom_range(0, 255))};
      default: it.operand = 16'($urandom());
    endcase
    return it;
  endfunction

  // hold one item on the input until it is taken
  task automatic send_item(input item_t it);
    in_ch.valid            <= 1'b1;
    in_ch.operation        <= it.operation;
    in_ch.reg_select       <= it.reg_select;
    in_ch.operand          <= it.operand;
    in_ch.branch_condition <= it.branch_condition;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic idle_gap();
    in_ch.valid <= 1'b0;
    repeat ($urandom_range(1, 8)) @(posedge clk);
  endtask

  task automatic send_paced(input item_t it);
    send_item(it);
    if ($urandom_range(0, 4) == 0) idle_gap();
  endtask

  // corners of every operation, flag edges and an unknown branch condition
  task automatic run_directed();
    send_paced(mk(OP_LDW, SEL_A, 16'h0000, COND_ALWAYS));
    send_paced(mk(OP_NEG, SEL_A, 16'hFFFF, COND_ALWAYS));
    send_paced(mk(OP_LDW, SEL_A, 16'h8000, COND_C));
    send_paced(mk(OP_NEG, SEL_A, 16'h0000, COND_ALWAYS));
    send_paced(mk(OP_BRANCH, SEL_A, 16'h0000, COND_V));
    send_paced(mk(OP_ASL, SEL_A, 16'h0000, COND_ALWAYS));
    send_paced(mk(OP_ROL, SEL_A, 16'h0000, COND_ALWAYS));
    send_paced(mk(OP_ROR, SEL_A, 16'h0000, COND_ALWAYS));
    send_paced(mk(OP_BRANCH, SEL_X, 16'hFFFF, COND_C));
    send_paced(mk(OP_LDW, SEL_X, 16'hFFFF, COND_ALWAYS));
    send_paced(mk(OP_ASR, SEL_X, 16'h0000, COND_ALWAYS));
    send_paced(mk(OP_NOT, SEL_X, 16'h0000, COND_ALWAYS));
    send_paced(mk(OP_ADD, SEL_X, 16'hFFFF, COND_ALWAYS));
    send_paced(mk(OP_ADD, SEL_X, 16'h0001, COND_ALWAYS));
    send_paced(mk(OP_LDW, SEL_A, 16'h7FFF, COND_ALWAYS));
    send_paced(mk(OP_ADD, SEL_A, 16'h0001, COND_ALWAYS));
    send_paced(mk(OP_SUB, SEL_A, 16'h0001, COND_ALWAYS));
    send_paced(mk(OP_CPW, SEL_A, 16'h8000, COND_ALWAYS));
    send_paced(mk(OP_BRANCH, SEL_A, 16'h0000, COND_LT));
    send_paced(mk(OP_CPB, SEL_A, 16'h00FF, COND_ALWAYS));
    send_paced(mk(OP_AND, SEL_A, 16'hAAAA, COND_ALWAYS));
    send_paced(mk(OP_OR, SEL_X, 16'h5555, COND_ALWAYS));
    send_paced(mk(OP_XOR, SEL_A, 16'hFFFF, COND_ALWAYS));
    send_paced(mk(OP_LDB, SEL_X, 16'hFF80, COND_ALWAYS));
    send_paced(mk(OP_BRANCH, SEL_X, 16'h0000, COND_UNKNOWN));
    send_paced(mk(OP_SUB, SEL_A, 16'h0000, COND_LE));
  endtask

  // reset, stimulus, drain, verdict
  initial begin
    int unsigned sent;
    int unsigned burst;
    int unsigned ops_hit;
    rst_n                  <= 1'b0;
    in_ch.valid            <= 1'b0;
    in_ch.operation        <= '0;
    in_ch.reg_select       <= 1'b0;
    in_ch.operand          <= '0;
    in_ch.branch_condition <= '0;
    items_sent   = 0;
    input_stalls = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();

    // random bursts, most of them followed by a random idle gap
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 24);
      repeat (burst) begin
        send_item(random_item());
        sent++;
      end
      if ($urandom_range(0, 3) != 0) idle_gap();
    end
    in_ch.valid <= 1'b0;

    while (shadow.expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    ops_hit = 0;
    for (int i = 0; i < 16; i++) begin
      if (shadow.op_seen[i]) ops_hit++;
    end
    $display("covered %0d of 16 operations in %0d items, %0d results checked, %0d branches taken",
             ops_hit, items_sent, shadow.results_seen, shadow.taken_count);
    $display("input held off on %0d cycles, including a %0d-cycle hold on the result side",
             input_stalls, HOLD_CYCLES);
    if (shadow.mismatches == 0) begin
      $display("tb_alu_with_status_flags: PASS");
    end else begin
      $display("tb_alu_with_status_flags: FAIL");
    end
    $finish;
  end

endmodule
